FILE: design/b62e_pkg.sv
// Package for the base62 escape encoder: word types, queue sizing and
// the alphabet lookup. No dependencies.
package b62e_pkg;

  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] CharI = 8'h69;  // 'i'
  localparam logic [7:0] CharA = 8'h61;  // 'a'
  localparam logic [7:0] CharB = 8'h62;  // 'b'
  localparam logic [7:0] CharC = 8'h63;  // 'c'
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharZero  = 8'h30;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_word_t;

  // One byte's worth of 6-bit groups, handed from front to back.
  typedef struct packed {
    logic       two_groups;
    logic [5:0] grp0;
    logic [5:0] grp1;
    logic       last;
  } grp_word_t;

  function automatic logic [7:0] enc_char(input logic [5:0] g);
    logic [7:0] gx;
    gx = {2'b00, g};
    if (g < 6'd26) begin
      enc_char = CharUpA + gx;
    end else if (g < 6'd52) begin
      enc_char = CharA + gx - 8'd26;
    end else if (g < 6'd62) begin
      enc_char = CharZero + gx - 8'd52;
    end else if (g == 6'd62) begin
      enc_char = CharPlus;
    end else begin
      enc_char = CharSlash;
    end
  endfunction

  function automatic logic [7:0] esc_suffix(input logic [7:0] ch);
    case (ch)
      CharI:     esc_suffix = CharA;
      CharPlus:  esc_suffix = CharB;
      CharSlash: esc_suffix = CharC;
      default:   esc_suffix = 8'h00;
    endcase
  endfunction

  function automatic logic is_escaped(input logic [7:0] ch);
    is_escaped = (ch == CharI) || (ch == CharPlus) || (ch == CharSlash);
  endfunction

endpackage

FILE: design/b62e_front.sv
// Front end: accepts input bytes, packs bits into 6-bit groups, holds
// leftover bits between bytes. Depends on b62e_pkg.
module b62e_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  b62e_pkg::in_word_t   in_word_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output b62e_pkg::grp_word_t  grp_o
);

  logic [3:0]  pend_bits_q, pend_bits_d;
  logic [2:0]  pend_cnt_q, pend_cnt_d;
  logic [11:0] val;
  logic [3:0]  rem_bits;
  logic [2:0]  rem_cnt;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign val        = {pend_bits_q, in_word_i.data_byte};

  always_comb begin
    grp_o.two_groups = 1'b0;
    grp_o.grp0       = val[7:2];
    grp_o.grp1       = 6'd0;
    grp_o.last       = in_word_i.last_byte;
    rem_bits         = {2'b00, val[1:0]};
    rem_cnt          = 3'd2;
    case (pend_cnt_q)
      3'd4: begin
        grp_o.two_groups = 1'b1;
        grp_o.grp0       = val[11:6];
        grp_o.grp1       = val[5:0];
        rem_bits         = 4'd0;
        rem_cnt          = 3'd0;
      end
      3'd2: begin
        grp_o.grp0 = val[9:4];
        rem_bits   = val[3:0];
        rem_cnt    = 3'd4;
      end
      default: begin
        grp_o.grp0 = val[7:2];
        rem_bits   = {2'b00, val[1:0]};
        rem_cnt    = 3'd2;
      end
    endcase
    // flush: pad leftover bits with zeros on the right
    if (in_word_i.last_byte && (rem_cnt != 3'd0)) begin
      grp_o.two_groups = 1'b1;
      grp_o.grp1 = (rem_cnt == 3'd4) ? {rem_bits, 2'b00} : {rem_bits[1:0], 4'b0000};
    end
  end

  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    if (push_o) begin
      if (in_word_i.last_byte) begin
        pend_bits_d = 4'd0;
        pend_cnt_d  = 3'd0;
      end else begin
        pend_bits_d = rem_bits;
        pend_cnt_d  = rem_cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= 4'd0;
      pend_cnt_q  <= 3'd0;
    end else begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

endmodule

FILE: design/b62e_queue.sv
// Short queue of group words between front and back ends.
// Depends on b62e_pkg.
module b62e_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  b62e_pkg::grp_word_t  push_word_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output b62e_pkg::grp_word_t  head_o
);

  b62e_pkg::grp_word_t mem_q [b62e_pkg::QDepth];
  logic [b62e_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [b62e_pkg::QCntW-1:0] cnt_q, cnt_d;

  localparam logic [b62e_pkg::QPtrW-1:0] PtrLast = b62e_pkg::QPtrW'(b62e_pkg::QDepth - 1);
  localparam logic [b62e_pkg::QCntW-1:0] CntFull = b62e_pkg::QCntW'(b62e_pkg::QDepth);

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

FILE: design/b62e_back.sv
// Back end: expands group words into characters with escapes, one per
// cycle when not stalled, via an output register. Depends on b62e_pkg.
module b62e_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  b62e_pkg::grp_word_t  head_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output b62e_pkg::out_word_t  out_word_o
);

  logic                sel_q, sel_d;
  logic                esc_ph_q, esc_ph_d;
  logic                out_valid_q, out_valid_d;
  b62e_pkg::out_word_t out_word_q, out_word_d;
  logic [5:0]          grp;
  logic [7:0]          ch;
  logic                esc;
  logic                load;
  logic                word_done;

  assign grp  = sel_q ? head_i.grp1 : head_i.grp0;
  assign ch   = b62e_pkg::enc_char(grp);
  assign esc  = b62e_pkg::is_escaped(ch);
  assign load = !empty_i && (!out_valid_q || !out_stall_i);
  assign word_done = (esc_ph_q || !esc) && (sel_q || !head_i.two_groups);
  assign pop_o = load && word_done;

  always_comb begin
    sel_d       = sel_q;
    esc_ph_d    = esc_ph_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d          = 1'b1;
      out_word_d.out_char  = esc_ph_q ? b62e_pkg::esc_suffix(ch)
                                      : (esc ? b62e_pkg::CharI : ch);
      out_word_d.last_char = word_done && head_i.last;
      if (word_done) begin
        sel_d    = 1'b0;
        esc_ph_d = 1'b0;
      end else if (esc && !esc_ph_q) begin
        esc_ph_d = 1'b1;
      end else begin
        sel_d    = 1'b1;
        esc_ph_d = 1'b0;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      esc_ph_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sel_q       <= sel_d;
      esc_ph_q    <= esc_ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: design/base62_escape_encoder.sv
// Top level of the base62 escape encoder: front end, group queue, back end.
// Depends on b62e_pkg, b62e_front, b62e_queue, b62e_back.
//
// Bytes go in MSB first and come out as base64-alphabet characters with
// 'i', '+' and '/' sent as "ia", "ib" and "ic"; the last byte of a message
// flushes leftover bits as a zero-padded group and its final character has
// last_char set. A byte yields one or two groups and so 1 to 4 characters;
// the output register delivers one character per cycle while out_stall_i
// is low and the queue holds a word. The front end takes a new byte
// every cycle while the two-entry group queue has room, so bytes keep
// arriving while the back end drains earlier ones. An accepted byte's
// groups enter the queue, then its first character the output register.
module base62_escape_encoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  b62e_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output b62e_pkg::out_word_t  out_word_o
);

  logic                push;
  logic                full;
  logic                pop;
  logic                empty;
  b62e_pkg::grp_word_t push_word;
  b62e_pkg::grp_word_t head;

  b62e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (full),
    .push_o     (push),
    .grp_o      (push_word)
  );

  b62e_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  b62e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for base62_escape_encoder: sends byte messages and predicts the escaped
// base64 character stream. Every output word is checked in order. Depends on b62e_pkg.
module tb_top;

  localparam int CycleLimit = 200000;
  localparam int RandomBytes = 500;
  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef logic [7:0] msg_t[$];
  typedef enum int {StallNone, StallRandom, StallRuns} stall_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                out_stall_i = 1'b0;
  b62e_pkg::in_word_t  in_word_i = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  b62e_pkg::out_word_t out_word_o;

  logic [3:0]          carry_bits = '0;
  logic [2:0]          carry_cnt = '0;
  b62e_pkg::out_word_t encoded_chars[$];
  int                  mismatch_cnt = 0;
  int                  cycle_cnt = 0;
  int                  burst_left = 0;
  stall_mode_e         stall_mode = StallNone;
  int                  stall_phase = 0;
  int                  stall_run = 0;
  logic                stall_hold = 1'b0;

  base62_escape_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void push_group(input logic [5:0] grp,
                                     inout b62e_pkg::out_word_t chars[$]);
    logic [7:0] ch;
    ch = Alphabet[8*(63 - int'(grp)) +: 8];
    if (ch == b62e_pkg::CharI || ch == b62e_pkg::CharPlus || ch == b62e_pkg::CharSlash) begin
      chars.push_back(b62e_pkg::out_word_t'{out_char: b62e_pkg::CharI, last_char: 1'b0});
      chars.push_back(b62e_pkg::out_word_t'{
        out_char: (ch == b62e_pkg::CharI) ? b62e_pkg::CharA :
                  ((ch == b62e_pkg::CharPlus) ? b62e_pkg::CharB : b62e_pkg::CharC),
        last_char: 1'b0});
    end else begin
      chars.push_back(b62e_pkg::out_word_t'{out_char: ch, last_char: 1'b0});
    end
  endfunction

  function automatic void encode_byte(input b62e_pkg::in_word_t w);
    logic [11:0]         acc;
    int                  pos;
    b62e_pkg::out_word_t chars[$];
    acc = {carry_bits, w.data_byte};
    pos = int'(carry_cnt) + 8;
    while (pos >= 6) begin
      pos -= 6;
      push_group(6'(acc >> pos), chars);
      acc &= (12'd1 << pos) - 12'd1;
    end
    if (w.last_byte) begin
      if (pos > 0) begin
        push_group(6'(acc << (6 - pos)), chars);
      end
      chars[chars.size() - 1].last_char = 1'b1;
      carry_bits = '0;
      carry_cnt  = '0;
    end else begin
      carry_bits = acc[3:0];
      carry_cnt  = 3'(pos);
    end
    foreach (chars[k]) encoded_chars.push_back(chars[k]);
  endfunction

  // Sender bursts: a fresh burst may start after a random gap, often none.
  task automatic send_byte(input b62e_pkg::in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    encode_byte(w);
  endtask

  task automatic send_msg(input msg_t bytes);
    foreach (bytes[k]) begin
      send_byte(b62e_pkg::in_word_t'{data_byte: bytes[k],
                                     last_byte: (k == bytes.size() - 1)});
    end
  endtask

  always @(posedge clk_i) begin : check_chars
    b62e_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (encoded_chars.size() == 0) begin
        $error("unexpected word: out_char %h last_char %b",
               out_word_o.out_char, out_word_o.last_char);
        mismatch_cnt++;
      end else begin
        want = encoded_chars.pop_front();
        if (out_word_o.out_char !== want.out_char) begin
          $error("out_char: expected %h, actual %h", want.out_char, out_word_o.out_char);
          mismatch_cnt++;
        end
        if (out_word_o.last_char !== want.last_char) begin
          $error("last_char: expected %b, actual %b", want.last_char, out_word_o.last_char);
          mismatch_cnt++;
        end
      end
    end
  end

  // Receiver stall pattern: stall_phase counts down and, at zero, a new mode is drawn at random.
  always @(posedge clk_i) begin
    if (stall_phase == 0) begin
      stall_mode  = stall_mode_e'($urandom_range(0, 2));
      stall_phase = 64;
    end
    stall_phase--;
    case (stall_mode)
      StallNone: begin
        out_stall_i <= 1'b0;
      end
      StallRandom: begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        if (stall_run == 0) begin
          stall_hold = ~stall_hold;
          stall_run  = $urandom_range(1, 10);
        end
        stall_run--;
        out_stall_i <= stall_hold;
      end
    endcase
  end

  task automatic test_single_byte_messages();
    send_msg({8'h00});
    send_msg({8'hFF});
    send_msg({8'h88});
    send_msg({8'hF8});
    send_msg({8'hFC});
  endtask

  task automatic test_exact_fit();
    send_msg({8'h00, 8'h00, 8'h00});
    send_msg({8'hFF, 8'hFF, 8'hFF});
  endtask

  task automatic test_partial_flush();
    send_msg({8'h12, 8'h34});
    send_msg({8'hA5, 8'h5A, 8'hC3, 8'h3C});
  endtask

  task automatic test_escapes();
    send_msg({8'hFB, 8'hEF, 8'hBE});
    send_msg({8'h8A, 8'h28, 8'hA2});
  endtask

  task automatic test_random_messages();
    msg_t       bytes;
    int         sent;
    int         len;
    logic [7:0] hot[8];
    hot  = '{8'hFF, 8'hFB, 8'hEF, 8'hBE, 8'h8A, 8'h28, 8'hA2, 8'h00};
    sent = 0;
    while (sent < RandomBytes) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      bytes.delete();
      repeat (len) begin
        if ($urandom_range(0, 4) == 0) bytes.push_back(hot[$urandom_range(0, 7)]);
        else bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_msg(bytes);
      sent += len;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_byte_messages();
    test_exact_fit();
    test_partial_flush();
    test_escapes();
    test_random_messages();
    in_valid_i <= 1'b0;
    while (encoded_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
